// File: sv/ctm_pkg.sv
// Shared types and constants of the tetrahedral color map.
// No dependencies; every other file imports this package.
`default_nettype none

package ctm_pkg;

    // Corner store geometry and port field width
    localparam int NUM_CORNERS = 8;
    localparam int CORNER_W    = 3;
    localparam int FIELD_W     = 16;

    // Weight format: signed, WEIGHT_FRAC fraction bits, magnitude limit 2^QUOT_BITS
    localparam int WEIGHT_FRAC = 20;
    localparam int QUOT_BITS   = 2 * WEIGHT_FRAC;
    localparam int WEIGHT_W    = QUOT_BITS + 2;

    // Stage counts of each pipeline section
    localparam int SELECT_LAT  = 4;
    localparam int SOLVE_LAT   = 3;
    localparam int DIV_LAT     = QUOT_BITS + 2;
    localparam int BLEND_LAT   = 3;
    localparam int PIPE_DEPTH  = SELECT_LAT + SOLVE_LAT + DIV_LAT + BLEND_LAT;

    // Request function codes
    localparam logic [1:0] FUNC_SRC = 2'd0;
    localparam logic [1:0] FUNC_TGT = 2'd1;
    localparam logic [1:0] FUNC_MAP = 2'd2;

    typedef logic [CORNER_W-1:0] t_corner;

    // Control that travels with each map request
    typedef struct packed {
        logic    valid;
        logic    deg;
        t_corner c2;
        t_corner c3;
    } t_tag;

endpackage

`default_nettype wire

// File: sv/ctm_req_if.sv
// Request channel of the color map: function, corner index and RGB payload.
// Depends on ctm_pkg for the field width.
`default_nettype none

interface ctm_req_if import ctm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic [CORNER_W-1:0] vertex_index;
    logic [FIELD_W-1:0]  red_in;
    logic [FIELD_W-1:0]  green_in;
    logic [FIELD_W-1:0]  blue_in;

    modport source (output valid, func, vertex_index, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, func, vertex_index, red_in, green_in, blue_in,
                    output ready);
endinterface

`default_nettype wire

// File: sv/ctm_rsp_if.sv
// Result channel of the color map: mapped RGB and the degenerate flag.
// Depends on ctm_pkg for the field width.
`default_nettype none

interface ctm_rsp_if import ctm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] red_out;
    logic [FIELD_W-1:0] green_out;
    logic [FIELD_W-1:0] blue_out;
    logic               degenerate;

    modport source (output valid, red_out, green_out, blue_out, degenerate,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, degenerate,
                    output ready);
endinterface

`default_nettype wire

// File: sv/cube_tetrahedral_color_map.sv
// Top level of the tetrahedral color map: corner stores, request decode, pipeline.
// Depends on ctm_pkg, ctm_req_if, ctm_rsp_if, ctm_select, ctm_solve, ctm_div, ctm_blend.
//
//   channel | dir | handshake           | carries
//   i_req   | in  | valid/ready         | func, vertex_index, red_in, green_in, blue_in
//   o_rsp   | out | valid/ready         | red_out, green_out, blue_out, degenerate
//
// A map request can enter every cycle while o_rsp is not stalled; the pipeline is made of the
// 40 quotient stages of the weight dividers plus 12 arithmetic stages around them.
// Corner writes give no result and wait until every map in flight has been delivered.
// Reset (i_rst_n low, synchronous) empties the pipeline; the corner stores keep
// no reset value and must be written before use.
// A stall on o_rsp freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module cube_tetrahedral_color_map import ctm_pkg::*; #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ctm_req_if.sink    i_req,
    ctm_rsp_if.source  o_rsp
);
    localparam int CW    = CHANNEL_BITS;
    localparam int TW    = 3 * CW + 6;
    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CW-1:0]    r_src [NUM_CORNERS][3];
    logic [CW-1:0]    r_tgt [NUM_CORNERS][3];
    logic [CNT_W-1:0] r_cnt;
    t_tag             r_dl  [DIV_LAT];

    logic                 n_adv;
    logic                 n_ready;
    logic                 n_map;
    logic                 n_wr;
    logic                 n_done;
    logic [CW-1:0]        n_p [3];
    t_tag                 n_sel_tag;
    t_tag                 n_sol_tag;
    logic signed [CW:0]   n_e1 [3];
    logic signed [CW:0]   n_e2 [3];
    logic signed [CW:0]   n_e3 [3];
    logic signed [CW:0]   n_b  [3];
    logic signed [TW-1:0] n_det;
    logic signed [TW-1:0] n_num [3];
    logic signed [WEIGHT_W-1:0] n_w [3];
    logic                 n_out_valid;

    // Mask the channels to the working width
    assign n_p[0] = CW'(i_req.red_in);
    assign n_p[1] = CW'(i_req.green_in);
    assign n_p[2] = CW'(i_req.blue_in);

    // Advance whenever the output register is free or being emptied
    assign n_adv = !n_out_valid || o_rsp.ready;

    // Accept maps at pipeline rate; writes only with nothing in flight
    always_comb begin
        unique case (i_req.func)
            FUNC_MAP:           n_ready = n_adv;
            FUNC_SRC, FUNC_TGT: n_ready = (r_cnt == '0);
            default:            n_ready = 1'b1;
        endcase
    end

    assign i_req.ready = n_ready;
    assign n_map  = i_req.valid && n_ready && (i_req.func == FUNC_MAP);
    assign n_wr   = i_req.valid && n_ready &&
                    ((i_req.func == FUNC_SRC) || (i_req.func == FUNC_TGT));
    assign n_done = n_out_valid && o_rsp.ready;

    // Write corner stores
    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            if (i_req.func == FUNC_SRC) begin
                r_src[i_req.vertex_index] <= n_p;
            end else begin
                r_tgt[i_req.vertex_index] <= n_p;
            end
        end
    end

    // Count maps accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CNT_W'(n_map) - CNT_W'(n_done);
        end
    end

    ctm_select #(.CHANNEL_BITS(CHANNEL_BITS)) u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (n_adv),
        .i_valid (i_req.valid && (i_req.func == FUNC_MAP)),
        .i_p     (n_p),
        .i_src   (r_src),
        .o_tag   (n_sel_tag),
        .o_e1    (n_e1),
        .o_e2    (n_e2),
        .o_e3    (n_e3),
        .o_b     (n_b)
    );

    ctm_solve #(.CHANNEL_BITS(CHANNEL_BITS)) u_solve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (n_adv),
        .i_tag   (n_sel_tag),
        .i_e1    (n_e1),
        .i_e2    (n_e2),
        .i_e3    (n_e3),
        .i_b     (n_b),
        .o_tag   (n_sol_tag),
        .o_det   (n_det),
        .o_num   (n_num)
    );

    for (genvar g = 0; g < 3; g++) begin : g_div
        ctm_div #(.NUM_W(TW)) u_div (
            .i_clk (i_clk),
            .i_adv (n_adv),
            .i_num (n_num[g]),
            .i_den (n_det),
            .o_w   (n_w[g])
        );
    end

    // Carry the control tag alongside the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_dl[i] <= '0;
            end
        end else if (n_adv) begin
            r_dl[0] <= n_sol_tag;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dl[i] <= r_dl[i-1];
            end
        end
    end

    ctm_blend #(.CHANNEL_BITS(CHANNEL_BITS)) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (n_adv),
        .i_tag   (r_dl[DIV_LAT-1]),
        .i_w     (n_w),
        .i_tgt   (r_tgt),
        .o_valid (n_out_valid),
        .o_red   (o_rsp.red_out),
        .o_green (o_rsp.green_out),
        .o_blue  (o_rsp.blue_out),
        .o_deg   (o_rsp.degenerate)
    );

    assign o_rsp.valid = n_out_valid;

    // A corner write never lands while a result is still waiting
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_wr |-> !n_out_valid)
        else $error("corner write accepted with a result pending");

    // A degenerate result is target corner 0
    a_deg_corner0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && o_rsp.degenerate) |->
            (o_rsp.red_out == FIELD_W'(r_tgt[0][0]) &&
             o_rsp.green_out == FIELD_W'(r_tgt[0][1]) &&
             o_rsp.blue_out == FIELD_W'(r_tgt[0][2])))
        else $error("degenerate result differs from target corner 0");

    // Every offered result belongs to an accepted map
    a_result_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_out_valid |-> (r_cnt != '0))
        else $error("result offered with no map in flight");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> ((r_cnt == '0) && !n_out_valid))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// File: sv/ctm_select.sv
// Front of the map pipeline: squared distances, tetrahedron choice, edge vectors.
// Depends on ctm_pkg; reads the source corner store of the top level.
`default_nettype none

module ctm_select import ctm_pkg::*; #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  logic [CHANNEL_BITS-1:0]      i_p   [3],
    input  logic [CHANNEL_BITS-1:0]      i_src [NUM_CORNERS][3],
    output t_tag                         o_tag,
    output logic signed [CHANNEL_BITS:0] o_e1 [3],
    output logic signed [CHANNEL_BITS:0] o_e2 [3],
    output logic signed [CHANNEL_BITS:0] o_e3 [3],
    output logic signed [CHANNEL_BITS:0] o_b  [3]
);
    localparam int CW  = CHANNEL_BITS;
    localparam int DW  = CW + 1;
    localparam int SQW = 2 * CW;
    localparam int DSW = SQW + 2;

    logic                   r0_valid;
    logic [CW-1:0]          r0_p  [3];
    logic                   r1_valid;
    logic [CW-1:0]          r1_p  [3];
    logic [SQW-1:0]         r1_sq [6][3];
    t_tag                   r2_tag;
    logic [CW-1:0]          r2_p  [3];
    t_tag                   r3_tag;
    logic signed [DW-1:0]   r3_e1 [3];
    logic signed [DW-1:0]   r3_e2 [3];
    logic signed [DW-1:0]   r3_e3 [3];
    logic signed [DW-1:0]   r3_b  [3];

    logic signed [DW-1:0]   n_d    [6][3];
    logic [SQW-1:0]         n_sq   [6][3];
    logic [DSW-1:0]         n_dist [6];
    t_tag                   n_tag2;
    logic signed [DW-1:0]   n_e1 [3];
    logic signed [DW-1:0]   n_e2 [3];
    logic signed [DW-1:0]   n_e3 [3];
    logic signed [DW-1:0]   n_b  [3];

    // Register the color
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (i_adv) begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r0_p <= i_p;
        end
    end

    // Square the channel offsets to corners 1 through 6
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            for (int k = 0; k < 3; k++) begin
                n_d[j][k]  = $signed({1'b0, i_src[j+1][k]}) - $signed({1'b0, r0_p[k]});
                n_sq[j][k] = SQW'(n_d[j][k] * n_d[j][k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_p  <= r0_p;
            r1_sq <= n_sq;
        end
    end

    // Sum distances and pick the nearest corner, ties to the later one
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            n_dist[j] = DSW'(r1_sq[j][0]) + DSW'(r1_sq[j][1]) + DSW'(r1_sq[j][2]);
        end
        n_tag2       = '0;
        n_tag2.valid = r1_valid;
        if (n_dist[0] < n_dist[1]) begin
            n_tag2.c2 = (n_dist[0] < n_dist[3]) ? 3'd1 : 3'd4;
        end else begin
            n_tag2.c2 = (n_dist[1] < n_dist[3]) ? 3'd2 : 3'd4;
        end
        priority if (n_tag2.c2 == 3'd1) begin
            n_tag2.c3 = (n_dist[2] < n_dist[4]) ? 3'd3 : 3'd5;
        end else if (n_tag2.c2 == 3'd2) begin
            n_tag2.c3 = (n_dist[2] < n_dist[5]) ? 3'd3 : 3'd6;
        end else begin
            n_tag2.c3 = (n_dist[4] < n_dist[5]) ? 3'd5 : 3'd6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_tag <= '0;
        end else if (i_adv) begin
            r2_tag <= n_tag2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_p <= r1_p;
        end
    end

    // Form edge vectors relative to corner 7
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_e1[k] = $signed({1'b0, i_src[0][k]}) - $signed({1'b0, i_src[7][k]});
            n_e2[k] = $signed({1'b0, i_src[r2_tag.c2][k]}) - $signed({1'b0, i_src[7][k]});
            n_e3[k] = $signed({1'b0, i_src[r2_tag.c3][k]}) - $signed({1'b0, i_src[7][k]});
            n_b[k]  = $signed({1'b0, r2_p[k]}) - $signed({1'b0, i_src[7][k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_tag <= '0;
        end else if (i_adv) begin
            r3_tag <= r2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_e1 <= n_e1;
            r3_e2 <= n_e2;
            r3_e3 <= n_e3;
            r3_b  <= n_b;
        end
    end

    assign o_tag = r3_tag;
    assign o_e1  = r3_e1;
    assign o_e2  = r3_e2;
    assign o_e3  = r3_e3;
    assign o_b   = r3_b;

endmodule

`default_nettype wire

// File: sv/ctm_solve.sv
// Cramer's rule numerators and determinant: cross products, dot products, sums.
// Depends on ctm_pkg; fed by ctm_select.
`default_nettype none

module ctm_solve import ctm_pkg::*; #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  t_tag                              i_tag,
    input  logic signed [CHANNEL_BITS:0]      i_e1 [3],
    input  logic signed [CHANNEL_BITS:0]      i_e2 [3],
    input  logic signed [CHANNEL_BITS:0]      i_e3 [3],
    input  logic signed [CHANNEL_BITS:0]      i_b  [3],
    output t_tag                              o_tag,
    output logic signed [3*CHANNEL_BITS+5:0]  o_det,
    output logic signed [3*CHANNEL_BITS+5:0]  o_num [3]
);
    localparam int DW = CHANNEL_BITS + 1;
    localparam int XW = 2 * DW + 1;
    localparam int PW = DW + XW;
    localparam int TW = 3 * CHANNEL_BITS + 6;

    t_tag                 r4_tag;
    logic signed [DW-1:0] r4_e1 [3];
    logic signed [DW-1:0] r4_b  [3];
    logic signed [XW-1:0] r4_x  [3];
    logic signed [XW-1:0] r4_y  [3];
    logic signed [XW-1:0] r4_z  [3];
    t_tag                 r5_tag;
    logic signed [PW-1:0] r5_pd [3];
    logic signed [PW-1:0] r5_p0 [3];
    logic signed [PW-1:0] r5_p1 [3];
    logic signed [PW-1:0] r5_p2 [3];
    t_tag                 r6_tag;
    logic signed [TW-1:0] r6_det;
    logic signed [TW-1:0] r6_num [3];

    logic signed [XW-1:0] n_x [3];
    logic signed [XW-1:0] n_y [3];
    logic signed [XW-1:0] n_z [3];
    logic signed [TW-1:0] n_det;
    logic signed [TW-1:0] n_num [3];
    t_tag                 n_tag6;

    function automatic logic signed [XW-1:0] f_cross(
        input logic signed [DW-1:0] a,
        input logic signed [DW-1:0] b,
        input logic signed [DW-1:0] c,
        input logic signed [DW-1:0] d
    );
        return XW'(a * b) - XW'(c * d);
    endfunction

    // Cross products e2 x e3, b x e3 and e2 x b
    always_comb begin
        n_x[0] = f_cross(i_e2[1], i_e3[2], i_e2[2], i_e3[1]);
        n_x[1] = f_cross(i_e2[2], i_e3[0], i_e2[0], i_e3[2]);
        n_x[2] = f_cross(i_e2[0], i_e3[1], i_e2[1], i_e3[0]);
        n_y[0] = f_cross(i_b[1],  i_e3[2], i_b[2],  i_e3[1]);
        n_y[1] = f_cross(i_b[2],  i_e3[0], i_b[0],  i_e3[2]);
        n_y[2] = f_cross(i_b[0],  i_e3[1], i_b[1],  i_e3[0]);
        n_z[0] = f_cross(i_e2[1], i_b[2],  i_e2[2], i_b[1]);
        n_z[1] = f_cross(i_e2[2], i_b[0],  i_e2[0], i_b[2]);
        n_z[2] = f_cross(i_e2[0], i_b[1],  i_e2[1], i_b[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_tag <= '0;
            r5_tag <= '0;
            r6_tag <= '0;
        end else if (i_adv) begin
            r4_tag <= i_tag;
            r5_tag <= r4_tag;
            r6_tag <= n_tag6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_e1 <= i_e1;
            r4_b  <= i_b;
            r4_x  <= n_x;
            r4_y  <= n_y;
            r4_z  <= n_z;
        end
    end

    // Per-component products of the four triple products
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < 3; k++) begin
                r5_pd[k] <= PW'(r4_e1[k] * r4_x[k]);
                r5_p0[k] <= PW'(r4_b[k]  * r4_x[k]);
                r5_p1[k] <= PW'(r4_e1[k] * r4_y[k]);
                r5_p2[k] <= PW'(r4_e1[k] * r4_z[k]);
            end
        end
    end

    // Sum the products and flag a zero determinant
    always_comb begin
        n_det    = TW'(r5_pd[0]) + TW'(r5_pd[1]) + TW'(r5_pd[2]);
        n_num[0] = TW'(r5_p0[0]) + TW'(r5_p0[1]) + TW'(r5_p0[2]);
        n_num[1] = TW'(r5_p1[0]) + TW'(r5_p1[1]) + TW'(r5_p1[2]);
        n_num[2] = TW'(r5_p2[0]) + TW'(r5_p2[1]) + TW'(r5_p2[2]);
        n_tag6     = r5_tag;
        n_tag6.deg = (n_det == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r6_det <= n_det;
            r6_num <= n_num;
        end
    end

    assign o_tag = r6_tag;
    assign o_det = r6_det;
    assign o_num = r6_num;

endmodule

`default_nettype wire

// File: sv/ctm_div.sv
// Pipelined restoring divider: round(num * 2^20 / den), saturated to +/- 2^40.
// Depends on ctm_pkg; one quotient bit per stage.
`default_nettype none

module ctm_div import ctm_pkg::*; #(
    parameter int NUM_W = 54
) (
    input  logic                       i_clk,
    input  logic                       i_adv,
    input  logic signed [NUM_W-1:0]    i_num,
    input  logic signed [NUM_W-1:0]    i_den,
    output logic signed [WEIGHT_W-1:0] o_w
);
    localparam int EXT_W = NUM_W + WEIGHT_FRAC;
    localparam logic [QUOT_BITS:0] Q_LIMIT = {1'b1, {QUOT_BITS{1'b0}}};

    logic [NUM_W-1:0]     r_rem [QUOT_BITS+1];
    logic [NUM_W-1:0]     r_den [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] r_xlo [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] r_q   [QUOT_BITS+1];
    logic                 r_neg [QUOT_BITS+1];
    logic                 r_sat [QUOT_BITS+1];
    logic signed [WEIGHT_W-1:0] r_w;

    logic [NUM_W-1:0]     n_nmag;
    logic [NUM_W-1:0]     n_dmag;
    logic                 n_sat;
    logic                 n_rnd;
    logic [QUOT_BITS:0]   n_qr;
    logic [QUOT_BITS:0]   n_qc;
    logic signed [WEIGHT_W-1:0] n_mag;

    // Take magnitudes and detect an integer quotient of 2^20 or more
    always_comb begin
        n_nmag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        n_dmag = i_den[NUM_W-1] ? NUM_W'(-i_den) : NUM_W'(i_den);
        n_sat  = EXT_W'(n_nmag) >= {n_dmag, {WEIGHT_FRAC{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0] <= n_sat ? '0 : (n_nmag >> WEIGHT_FRAC);
            r_den[0] <= n_dmag;
            r_xlo[0] <= {n_nmag[WEIGHT_FRAC-1:0], {WEIGHT_FRAC{1'b0}}};
            r_q[0]   <= '0;
            r_neg[0] <= i_num[NUM_W-1] ^ i_den[NUM_W-1];
            r_sat[0] <= n_sat;
        end
    end

    // One quotient bit per stage
    for (genvar g = 0; g < QUOT_BITS; g++) begin : g_step
        logic [NUM_W:0] n_rs;
        logic [NUM_W:0] n_df;
        logic           n_ge;

        assign n_rs = {r_rem[g], r_xlo[g][QUOT_BITS-1]};
        assign n_df = n_rs - {1'b0, r_den[g]};
        assign n_ge = n_rs >= {1'b0, r_den[g]};

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[g+1] <= n_ge ? n_df[NUM_W-1:0] : n_rs[NUM_W-1:0];
                r_den[g+1] <= r_den[g];
                r_xlo[g+1] <= {r_xlo[g][QUOT_BITS-2:0], 1'b0};
                r_q[g+1]   <= {r_q[g][QUOT_BITS-2:0], n_ge};
                r_neg[g+1] <= r_neg[g];
                r_sat[g+1] <= r_sat[g];
            end
        end
    end

    // Round half away from zero, saturate, restore the sign
    always_comb begin
        n_rnd = {r_rem[QUOT_BITS], 1'b0} >= {1'b0, r_den[QUOT_BITS]};
        n_qr  = (QUOT_BITS+1)'(r_q[QUOT_BITS]) + (QUOT_BITS+1)'(n_rnd);
        n_qc  = (r_sat[QUOT_BITS] || (n_qr > Q_LIMIT)) ? Q_LIMIT : n_qr;
        n_mag = $signed({1'b0, n_qc});
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_w <= r_neg[QUOT_BITS] ? -n_mag : n_mag;
        end
    end

    assign o_w = r_w;

endmodule

`default_nettype wire

// File: sv/ctm_blend.sv
// Back of the map pipeline: fourth weight, target blend, rounding and output register.
// Depends on ctm_pkg; reads the target corner store of the top level.
`default_nettype none

module ctm_blend import ctm_pkg::*; #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  t_tag                       i_tag,
    input  logic signed [WEIGHT_W-1:0] i_w   [3],
    input  logic [CHANNEL_BITS-1:0]    i_tgt [NUM_CORNERS][3],
    output logic                       o_valid,
    output logic [FIELD_W-1:0]         o_red,
    output logic [FIELD_W-1:0]         o_green,
    output logic [FIELD_W-1:0]         o_blue,
    output logic                       o_deg
);
    localparam int CW  = CHANNEL_BITS;
    localparam int SW  = WEIGHT_W + 2;
    localparam int PRW = CW + 1 + WEIGHT_W;
    localparam int AW  = PRW + 2;
    localparam logic signed [SW-1:0] W_ONE  = SW'(1) << WEIGHT_FRAC;
    localparam logic signed [SW-1:0] W_LIM  = SW'(1) << QUOT_BITS;
    localparam logic signed [AW-1:0] A_HALF = AW'(1) << (WEIGHT_FRAC - 1);
    localparam logic signed [AW-1:0] A_CMAX = (AW'(1) << CW) - AW'(1);

    t_tag                        r1_tag;
    logic signed [WEIGHT_W-1:0]  r1_w [4];
    logic [CW-1:0]               r1_t [4][3];
    t_tag                        r2_tag;
    logic signed [PRW-1:0]       r2_pr [4][3];
    logic [CW-1:0]               r2_t0 [3];
    logic                        r3_valid;
    logic [CW-1:0]               r3_ch [3];
    logic                        r3_deg;

    logic signed [SW-1:0]        n_w3s;
    logic signed [WEIGHT_W-1:0]  n_w3;
    logic signed [AW-1:0]        n_acc [3];
    logic signed [AW-1:0]        n_sh  [3];
    logic [CW-1:0]               n_ch  [3];

    // Complete the weights and fetch the four target corners
    always_comb begin
        n_w3s = W_ONE - SW'(i_w[0]) - SW'(i_w[1]) - SW'(i_w[2]);
        if (n_w3s > W_LIM) begin
            n_w3 = WEIGHT_W'(W_LIM);
        end else if (n_w3s < -W_LIM) begin
            n_w3 = WEIGHT_W'(-W_LIM);
        end else begin
            n_w3 = WEIGHT_W'(n_w3s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag   <= '0;
            r2_tag   <= '0;
            r3_valid <= 1'b0;
        end else if (i_adv) begin
            r1_tag   <= i_tag;
            r2_tag   <= r1_tag;
            r3_valid <= r2_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_w[0] <= i_w[0];
            r1_w[1] <= i_w[1];
            r1_w[2] <= i_w[2];
            r1_w[3] <= n_w3;
            r1_t[0] <= i_tgt[0];
            r1_t[1] <= i_tgt[i_tag.c2];
            r1_t[2] <= i_tgt[i_tag.c3];
            r1_t[3] <= i_tgt[7];
        end
    end

    // Weight each target channel
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 4; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r2_pr[i][k] <= PRW'($signed({1'b0, r1_t[i][k]}) * r1_w[i]);
                end
            end
            r2_t0 <= r1_t[0];
        end
    end

    // Sum, round half up, clamp to full scale; a degenerate map takes target corner 0
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_acc[k] = AW'(r2_pr[0][k]) + AW'(r2_pr[1][k]) + AW'(r2_pr[2][k])
                     + AW'(r2_pr[3][k]);
            n_sh[k]  = (n_acc[k] + A_HALF) >>> WEIGHT_FRAC;
            if (r2_tag.deg) begin
                n_ch[k] = r2_t0[k];
            end else if (n_acc[k] <= 0) begin
                n_ch[k] = '0;
            end else if (n_sh[k] > A_CMAX) begin
                n_ch[k] = CW'(A_CMAX);
            end else begin
                n_ch[k] = CW'(n_sh[k]);
            end
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_ch  <= n_ch;
            r3_deg <= r2_tag.deg;
        end
    end

    assign o_valid = r3_valid;
    assign o_red   = FIELD_W'(r3_ch[0]);
    assign o_green = FIELD_W'(r3_ch[1]);
    assign o_blue  = FIELD_W'(r3_ch[2]);
    assign o_deg   = r3_deg;

endmodule

`default_nettype wire

// File: tb/sv/tb_cube_tetrahedral_color_map.sv
// Testbench of the tetrahedral color map: random and directed requests, scoreboard check.
// Depends on ctm_pkg, ctm_req_if, ctm_rsp_if and cube_tetrahedral_color_map.
`timescale 1ns / 100ps

module tb_cube_tetrahedral_color_map;
    import ctm_pkg::*;

    localparam int CBITS = 16;
    localparam longint WLIM = 64'sd1 << 40;
    // Function code the block accepts and ignores
    localparam logic [1:0] FUNC_IDLE = 2'd3;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        deg;
    } t_color;

    // Predictor of the color map and store of expected colors
    class color_scoreboard;
        longint unsigned src_pos[8][3];
        longint unsigned tgt_col[8][3];
        t_color pending[$];
        int errors;
        int checked;
        int degens;

        function new();
            errors = 0;
            checked = 0;
            degens = 0;
            for (int i = 0; i < 8; i++) begin
                for (int k = 0; k < 3; k++) begin
                    src_pos[i][k] = 0;
                    tgt_col[i][k] = 0;
                end
            end
        endfunction

        function longint unsigned dist2(int c, longint p[3]);
            longint unsigned s;
            longint d;
            s = 0;
            for (int k = 0; k < 3; k++) begin
                d = longint'(src_pos[c][k]) - p[k];
                s += longint'(d * d);
            end
            return s;
        endfunction

        function int pick(int a, int b, longint p[3]);
            return (dist2(a, p) < dist2(b, p)) ? a : b;
        endfunction

        function longint det3(longint a[3], longint b[3], longint c[3]);
            return a[0] * (b[1] * c[2] - b[2] * c[1])
                 + a[1] * (b[2] * c[0] - b[0] * c[2])
                 + a[2] * (b[0] * c[1] - b[1] * c[0]);
        endfunction

        function longint sat_w(longint w);
            if (w > WLIM) return WLIM;
            if (w < -WLIM) return -WLIM;
            return w;
        endfunction

        // Round num * 2^20 / den half away from zero, saturated
        function longint weight_div(longint num, longint den);
            bit neg;
            longint unsigned n, d, qi, r, q;
            neg = (num < 0) != (den < 0);
            n = num < 0 ? longint'(-num) : num;
            d = den < 0 ? longint'(-den) : den;
            qi = n / d;
            r = n % d;
            if (qi >= (64'd1 << WEIGHT_FRAC)) begin
                q = WLIM;
            end else begin
                q = qi;
                for (int i = 0; i < WEIGHT_FRAC; i++) begin
                    r = r << 1;
                    q = q << 1;
                    if (r >= d) begin
                        r -= d;
                        q |= 1;
                    end
                end
                if (r >= d - r) q++;
                if (q > WLIM) q = WLIM;
            end
            return neg ? -longint'(q) : longint'(q);
        endfunction

        // Note an accepted request: update corners or queue the mapped color
        function void note_request(logic [1:0] fn, logic [2:0] idx, logic [15:0] r,
                                   logic [15:0] g, logic [15:0] b);
            longint p[3], e1[3], e2[3], e3[3], bv[3], w[4];
            longint det, acc;
            longint unsigned rr;
            int c2, c3, sel[4];
            t_color res;
            p[0] = longint'(r);
            p[1] = longint'(g);
            p[2] = longint'(b);
            if (fn == FUNC_SRC || fn == FUNC_TGT) begin
                for (int k = 0; k < 3; k++) begin
                    if (fn == FUNC_SRC) src_pos[idx][k] = p[k];
                    else tgt_col[idx][k] = p[k];
                end
                return;
            end
            if (fn != FUNC_MAP) return;
            if (dist2(1, p) < dist2(2, p)) c2 = pick(1, 4, p);
            else c2 = pick(2, 4, p);
            if (c2 == 1) c3 = pick(3, 5, p);
            else if (c2 == 2) c3 = pick(3, 6, p);
            else c3 = pick(5, 6, p);
            for (int k = 0; k < 3; k++) begin
                e1[k] = longint'(src_pos[0][k]) - longint'(src_pos[7][k]);
                e2[k] = longint'(src_pos[c2][k]) - longint'(src_pos[7][k]);
                e3[k] = longint'(src_pos[c3][k]) - longint'(src_pos[7][k]);
                bv[k] = p[k] - longint'(src_pos[7][k]);
            end
            det = det3(e1, e2, e3);
            if (det == 0) begin
                res.red = 16'(tgt_col[0][0]);
                res.green = 16'(tgt_col[0][1]);
                res.blue = 16'(tgt_col[0][2]);
                res.deg = 1'b1;
                degens++;
                pending.push_back(res);
                return;
            end
            w[0] = sat_w(weight_div(det3(bv, e2, e3), det));
            w[1] = sat_w(weight_div(det3(e1, bv, e3), det));
            w[2] = sat_w(weight_div(det3(e1, e2, bv), det));
            w[3] = sat_w((64'sd1 << WEIGHT_FRAC) - w[0] - w[1] - w[2]);
            sel[0] = 0;
            sel[1] = c2;
            sel[2] = c3;
            sel[3] = 7;
            for (int k = 0; k < 3; k++) begin
                acc = 0;
                for (int i = 0; i < 4; i++) acc += longint'(tgt_col[sel[i]][k]) * w[i];
                if (acc <= 0) begin
                    rr = 0;
                end else begin
                    rr = (longint'(acc) + (64'd1 << (WEIGHT_FRAC - 1))) >> WEIGHT_FRAC;
                    if (rr > (1 << CBITS) - 1) rr = (1 << CBITS) - 1;
                end
                if (k == 0) res.red = 16'(rr);
                else if (k == 1) res.green = 16'(rr);
                else res.blue = 16'(rr);
            end
            res.deg = 1'b0;
            pending.push_back(res);
        endfunction

        // Compare one delivered color with the oldest expectation
        function void check_result(t_color got);
            t_color exp_c;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_c = pending.pop_front();
            checked++;
            if (got.red !== exp_c.red)
                $display("%0t: red expected %h actual %h", $time, exp_c.red, got.red);
            if (got.green !== exp_c.green)
                $display("%0t: green expected %h actual %h", $time, exp_c.green, got.green);
            if (got.blue !== exp_c.blue)
                $display("%0t: blue expected %h actual %h", $time, exp_c.blue, got.blue);
            if (got.deg !== exp_c.deg)
                $display("%0t: degenerate expected %b actual %b", $time, exp_c.deg, got.deg);
            if (got !== exp_c) errors++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit calm = 1'b0;
    color_scoreboard sb;

    ctm_req_if req_ch();
    ctm_rsp_if rsp_ch();

    cube_tetrahedral_color_map #(.CHANNEL_BITS(CBITS)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_ch.sink),
        .o_rsp(rsp_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_SRC;
        req_ch.vertex_index = '0;
        req_ch.red_in = '0;
        req_ch.green_in = '0;
        req_ch.blue_in = '0;
        rsp_ch.ready = 1'b0;
        sb = new();
    end

    // Send one request, idling at random before it; ready is settled by the falling edge
    task automatic send(logic [1:0] fn, logic [2:0] idx, logic [15:0] r,
                        logic [15:0] g, logic [15:0] b);
        bit took;
        while (!calm && $urandom_range(99) < 30) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= fn;
        req_ch.vertex_index <= idx;
        req_ch.red_in <= r;
        req_ch.green_in <= g;
        req_ch.blue_in <= b;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = req_ch.ready;
            @(posedge i_clk);
        end
        sb.note_request(fn, idx, r, g, b);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // Load a cube: unit corners, unit corners with jitter, or fully random
    task automatic load_cube(int style);
        logic [15:0] c[3];
        for (int i = 0; i < 8; i++) begin
            for (int k = 0; k < 3; k++) begin
                if (style == 0) c[k] = i[k] ? 16'hFFFF : 16'h0000;
                else if (style == 1)
                    c[k] = (i[k] ? 16'hF000 : 16'h0800) + 16'($urandom_range(2047));
                else c[k] = 16'($urandom());
            end
            send(FUNC_SRC, i[2:0], c[0], c[1], c[2]);
            for (int k = 0; k < 3; k++)
                c[k] = (style == 0) ? (i[k] ? 16'hFFFF : 16'h0000) : 16'($urandom());
            send(FUNC_TGT, i[2:0], c[0], c[1], c[2]);
        end
    endtask

    // Collapse the input cube to one point so every map is degenerate
    task automatic flat_cube();
        for (int i = 0; i < 8; i++) send(FUNC_SRC, i[2:0], 16'h4000, 16'h4000, 16'h4000);
    endtask

    // Result side: check at the falling edge, where the next handshake is settled
    always @(negedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result({rsp_ch.red_out, rsp_ch.green_out, rsp_ch.blue_out,
                             rsp_ch.degenerate});
    end

    // Result side: accept with random stalls
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
        end
    end

    initial begin
        int sent;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: unit cube, corners, extremes, ties, an ignored code, a flat cube
        load_cube(0);
        send(FUNC_MAP, 3'd0, 16'h0000, 16'h0000, 16'h0000);
        send(FUNC_MAP, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(FUNC_MAP, 3'd0, 16'h8000, 16'h8000, 16'h8000);
        send(FUNC_MAP, 3'd0, 16'hFFFF, 16'h0000, 16'h0000);
        send(FUNC_MAP, 3'd0, 16'h0000, 16'hFFFF, 16'h0000);
        send(FUNC_MAP, 3'd0, 16'h0000, 16'h0000, 16'hFFFF);
        send(FUNC_MAP, 3'd0, 16'hFFFF, 16'hFFFF, 16'h0000);
        send(FUNC_IDLE, 3'd5, 16'h1234, 16'h5678, 16'h9ABC);
        send(FUNC_MAP, 3'd0, 16'h5555, 16'hAAAA, 16'h1234);
        drain();
        flat_cube();
        send(FUNC_MAP, 3'd0, 16'h4000, 16'h4000, 16'h4000);
        send(FUNC_MAP, 3'd0, 16'hFFFF, 16'h0000, 16'h8000);
        drain();

        // Random: mostly maps on varied cubes, occasional rewrites and noise
        sent = 0;
        while (sent < 1900) begin
            if (sent % 400 == 0) begin
                drain();
                calm = (sent == 800);
                case ($urandom_range(3))
                    0: load_cube(0);
                    1, 2: load_cube(1);
                    default: load_cube(2);
                endcase
            end
            case ($urandom_range(19))
                0: send(FUNC_SRC, 3'($urandom()), rand_chan(), rand_chan(), rand_chan());
                1: send(FUNC_TGT, 3'($urandom()), rand_chan(), rand_chan(), rand_chan());
                2: send(FUNC_IDLE, 3'($urandom()), 16'($urandom()), 16'($urandom()),
                        16'($urandom()));
                default: send(FUNC_MAP, 3'($urandom()), rand_chan(), rand_chan(), rand_chan());
            endcase
            sent++;
        end
        calm = 1'b0;
        drain();

        $display("Checked %0d mapped colors (%0d degenerate) over several corner cubes,",
                 sb.checked, sb.degens);
        $display("with random idle on both channels and a no-idle stretch.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
sv/ctm_pkg.sv
sv/ctm_req_if.sv
sv/ctm_rsp_if.sv
sv/ctm_select.sv
sv/ctm_solve.sv
sv/ctm_div.sv
sv/ctm_blend.sv
sv/cube_tetrahedral_color_map.sv
tb/sv/tb_cube_tetrahedral_color_map.sv
